// ===== rtl/ddm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Differential drive mixer package
// Field widths, register codes, output limits and width helpers shared by
// the mixer pipeline, its interfaces and the top level.
// ============================================================================
package ddm_pkg;

    localparam int IN_W      = 16;
    localparam int OUT_W     = 17;
    localparam int BIAS_W    = 9;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DESAT_BIAS = 1'd1;

    // Drive mode codes.
    localparam logic DRIVE_ARCADE    = 1'b0;
    localparam logic DRIVE_CURVATURE = 1'b1;

    localparam logic [BIAS_W-1:0] BIAS_HALF = 9'd128;

    localparam logic signed [OUT_W-1:0] OUT_MAX = 17'sh0FFFF;
    localparam logic signed [OUT_W-1:0] OUT_MIN = 17'sh10000;

    typedef struct packed {
        logic valid;
        logic curv;
    } t_mix_ctl;

    // Full scale, 127 in the chosen fixed point format.
    function automatic longint full_scale(input int frac_bits);
        return longint'(127) << frac_bits;
    endfunction

    // Width of the curvature terms left = t + k and right = t - k.
    function automatic int a_width(input int frac_bits);
        int kw;
        kw = 25 - frac_bits;
        return ((kw + 1 > IN_W) ? kw + 1 : IN_W) + 1;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/ddm_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Differential drive mixer channels
// Valid/ready channels for samples, wheel power results and register writes.
// ============================================================================
interface ddm_in_if;
    logic                             valid;
    logic                             ready;
    logic signed [ddm_pkg::IN_W-1:0]  throttle_in;
    logic signed [ddm_pkg::IN_W-1:0]  turn_in;

    modport source (output valid, output throttle_in, output turn_in, input ready);
    modport sink   (input valid, input throttle_in, input turn_in, output ready);
endinterface

interface ddm_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [ddm_pkg::OUT_W-1:0] left_power;
    logic signed [ddm_pkg::OUT_W-1:0] right_power;

    modport source (output valid, output left_power, output right_power, input ready);
    modport sink   (input valid, input left_power, input right_power, output ready);
endinterface

interface ddm_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [ddm_pkg::CFG_IDX_W-1:0]     index;
    logic [ddm_pkg::BIAS_W-1:0]        data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/ddm_mix.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Differential drive mixer, mixing stages
// Seven register stages: arcade desaturation with fixed point quotients and
// the curvature turn term, giving the saturated arcade result and the raw
// curvature sums.
// ============================================================================
module ddm_mix #(
    parameter  int FRAC_BITS = 8,
    localparam int AW        = ddm_pkg::a_width(FRAC_BITS)
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_en,
    input  wire logic                              i_valid,
    input  wire logic signed [ddm_pkg::IN_W-1:0]   i_throttle,
    input  wire logic signed [ddm_pkg::IN_W-1:0]   i_turn,
    input  wire logic                              i_mode,
    input  wire logic [ddm_pkg::BIAS_W-1:0]        i_bias,
    output      ddm_pkg::t_mix_ctl                 o_ctl,
    output      logic signed [ddm_pkg::OUT_W-1:0]  o_arc_l,
    output      logic signed [ddm_pkg::OUT_W-1:0]  o_arc_r,
    output      logic signed [AW-1:0]              o_a,
    output      logic signed [AW-1:0]              o_b
);

    localparam longint FS     = ddm_pkg::full_scale(FRAC_BITS);
    localparam longint DEN    = FS * 256;
    localparam int     FMAG_W = $clog2(DEN + longint'(511 * 32768) + 1);
    localparam int     FX_W   = FMAG_W + 2;
    localparam int     PA     = 16 + FMAG_W;
    localparam int     N1     = PA - FRAC_BITS - 8;
    localparam int     S_A    = N1 + 7;
    localparam int     TP_W   = 2 * N1 + 1;
    localparam int     QA_W   = N1 - 6;
    localparam int     TQ_W   = QA_W + 1;
    localparam int     SM_W   = QA_W + 2;
    localparam int     PW     = 31 - FRAC_BITS;
    localparam int     S_K    = PW + 7;
    localparam int     KP_W   = 2 * PW + 1;
    localparam int     KW     = PW - 6;

    // Reciprocals of 127, exact for every value of the given width.
    localparam logic [N1:0] RECIP_A = (N1 + 1)'(((64'd1 << S_A) + 64'd126) / 64'd127);
    localparam logic [PW:0] RECIP_K = (PW + 1)'(((64'd1 << S_K) + 64'd126) / 64'd127);

    localparam logic signed [FX_W-1:0] DEN_S  = FX_W'(DEN);
    localparam logic signed [SM_W-1:0] SM_MAX = SM_W'(65535);
    localparam logic signed [SM_W-1:0] SM_MIN = SM_W'(-65536);

    // Stage 1: magnitudes, effective bias, mode.
    logic                  r1_valid, r1_curv;
    logic signed [15:0]    r1_t, r1_r;
    logic [15:0]           r1_at, r1_ar;
    logic [8:0]            r1_bias;
    // Stage 2: shrink factors and curvature product.
    logic                  r2_valid, r2_curv, r2_sat;
    logic signed [15:0]    r2_t, r2_r;
    logic [15:0]           r2_at, r2_ar;
    logic signed [FX_W-1:0] r2_ft, r2_fr;
    logic signed [32:0]    r2_p;
    // Stage 3: factor magnitudes and signs.
    logic                  r3_valid, r3_curv, r3_sat, r3_st, r3_sr, r3_sk;
    logic signed [15:0]    r3_t, r3_r;
    logic [15:0]           r3_at, r3_ar;
    logic [FMAG_W-1:0]     r3_ftm, r3_frm;
    logic [PW-1:0]         r3_pm;
    // Stage 4: products.
    logic                  r4_valid, r4_curv, r4_sat, r4_st, r4_sr, r4_sk;
    logic signed [15:0]    r4_t, r4_r;
    logic [PA-1:0]         r4_nm, r4_rm;
    logic [KP_W-1:0]       r4_kp;
    // Stage 5: reciprocal products.
    logic                  r5_valid, r5_curv, r5_sat, r5_st, r5_sr, r5_sk;
    logic signed [15:0]    r5_t, r5_r;
    logic [TP_W-1:0]       r5_tp, r5_rp;
    logic [KW-1:0]         r5_km;
    // Stage 6: signed terms.
    logic                  r6_valid, r6_curv;
    logic signed [TQ_W-1:0] r6_tq, r6_rq;
    logic signed [AW-1:0]  r6_a, r6_b;
    // Stage 7: saturated arcade result.
    logic                  r7_valid, r7_curv;
    logic signed [16:0]    r7_arc_l, r7_arc_r;
    logic signed [AW-1:0]  r7_a, r7_b;

    logic [15:0]           n1_at, n1_ar;
    logic                  n1_curv;
    logic [8:0]            n1_bias;
    logic [16:0]           n2_sum;
    logic [24:0]           n2_bp;
    logic signed [9:0]     n2_bc;
    logic signed [26:0]    n2_frp;
    logic [32:0]           n3_pabs;
    logic [QA_W-1:0]       n6_nt, n6_nr;
    logic signed [SM_W-1:0] n7_l, n7_r;

    always_comb begin
        n1_at   = i_throttle[15] ? 16'(-i_throttle) : 16'(i_throttle);
        n1_ar   = i_turn[15] ? 16'(-i_turn) : 16'(i_turn);
        n1_curv = (i_mode == ddm_pkg::DRIVE_CURVATURE) && (i_throttle != '0);
        // Curvature with zero throttle falls back to arcade at half bias.
        n1_bias = (i_mode == ddm_pkg::DRIVE_CURVATURE) ? ddm_pkg::BIAS_HALF : i_bias;

        n2_sum = {1'b0, r1_at} + {1'b0, r1_ar};
        n2_bp  = 25'(r1_bias) * 25'(r1_ar);
        n2_bc  = 10'sd256 - $signed({1'b0, r1_bias});
        n2_frp = 27'(n2_bc) * 27'($signed({1'b0, r1_at}));

        n3_pabs = r2_p[32] ? 33'(-r2_p) : 33'(r2_p);

        n6_nt = r5_tp[TP_W-1:S_A];
        n6_nr = r5_rp[TP_W-1:S_A];

        n7_l = SM_W'(r6_tq) + SM_W'(r6_rq);
        n7_r = SM_W'(r6_tq) - SM_W'(r6_rq);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
            r7_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
            r6_valid <= r5_valid;
            r7_valid <= r6_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_curv <= n1_curv;
            r1_t    <= i_throttle;
            r1_r    <= i_turn;
            r1_at   <= n1_at;
            r1_ar   <= n1_ar;
            r1_bias <= n1_bias;

            r2_curv <= r1_curv;
            r2_t    <= r1_t;
            r2_r    <= r1_r;
            r2_at   <= r1_at;
            r2_ar   <= r1_ar;
            r2_sat  <= 64'(n2_sum) > FS;
            r2_ft   <= DEN_S - $signed(FX_W'(n2_bp));
            r2_fr   <= DEN_S - FX_W'(n2_frp);
            r2_p    <= 33'($signed({1'b0, r1_at})) * 33'(r1_r);

            r3_curv <= r2_curv;
            r3_sat  <= r2_sat;
            r3_t    <= r2_t;
            r3_r    <= r2_r;
            r3_at   <= r2_at;
            r3_ar   <= r2_ar;
            r3_ftm  <= FMAG_W'(r2_ft[FX_W-1] ? -r2_ft : r2_ft);
            r3_frm  <= FMAG_W'(r2_fr[FX_W-1] ? -r2_fr : r2_fr);
            r3_st   <= r2_t[15] ^ r2_ft[FX_W-1];
            r3_sr   <= r2_r[15] ^ r2_fr[FX_W-1];
            r3_pm   <= n3_pabs[30:FRAC_BITS];
            r3_sk   <= r2_p[32];

            r4_curv <= r3_curv;
            r4_sat  <= r3_sat;
            r4_st   <= r3_st;
            r4_sr   <= r3_sr;
            r4_sk   <= r3_sk;
            r4_t    <= r3_t;
            r4_r    <= r3_r;
            r4_nm   <= PA'(r3_at) * PA'(r3_ftm);
            r4_rm   <= PA'(r3_ar) * PA'(r3_frm);
            r4_kp   <= KP_W'(r3_pm) * KP_W'(RECIP_K);

            // The power of two part of the divisor is a shift ahead of the
            // reciprocal multiply by 127.
            r5_curv <= r4_curv;
            r5_sat  <= r4_sat;
            r5_st   <= r4_st;
            r5_sr   <= r4_sr;
            r5_sk   <= r4_sk;
            r5_t    <= r4_t;
            r5_r    <= r4_r;
            r5_tp   <= TP_W'(r4_nm[PA-1:FRAC_BITS+8]) * TP_W'(RECIP_A);
            r5_rp   <= TP_W'(r4_rm[PA-1:FRAC_BITS+8]) * TP_W'(RECIP_A);
            r5_km   <= r4_kp[KP_W-1:S_K];

            r6_curv <= r5_curv;
            if (r5_sat) begin
                r6_tq <= r5_st ? -$signed(TQ_W'(n6_nt)) : $signed(TQ_W'(n6_nt));
                r6_rq <= r5_sr ? -$signed(TQ_W'(n6_nr)) : $signed(TQ_W'(n6_nr));
            end else begin
                r6_tq <= TQ_W'(r5_t);
                r6_rq <= TQ_W'(r5_r);
            end
            if (r5_sk) begin
                r6_a <= AW'(r5_t) - $signed(AW'(r5_km));
                r6_b <= AW'(r5_t) + $signed(AW'(r5_km));
            end else begin
                r6_a <= AW'(r5_t) + $signed(AW'(r5_km));
                r6_b <= AW'(r5_t) - $signed(AW'(r5_km));
            end

            r7_curv <= r6_curv;
            r7_a    <= r6_a;
            r7_b    <= r6_b;
            if (n7_l > SM_MAX) begin
                r7_arc_l <= ddm_pkg::OUT_MAX;
            end else if (n7_l < SM_MIN) begin
                r7_arc_l <= ddm_pkg::OUT_MIN;
            end else begin
                r7_arc_l <= n7_l[16:0];
            end
            if (n7_r > SM_MAX) begin
                r7_arc_r <= ddm_pkg::OUT_MAX;
            end else if (n7_r < SM_MIN) begin
                r7_arc_r <= ddm_pkg::OUT_MIN;
            end else begin
                r7_arc_r <= n7_r[16:0];
            end
        end
    end

    assign o_ctl.valid = r7_valid;
    assign o_ctl.curv  = r7_curv;
    assign o_arc_l     = r7_arc_l;
    assign o_arc_r     = r7_arc_r;
    assign o_a         = r7_a;
    assign o_b         = r7_b;

endmodule
`default_nettype wire

// ===== rtl/ddm_scale.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Differential drive mixer, curvature normalization
// Finds the larger curvature magnitude and, when it passes full scale,
// divides both sides down with a pipelined restoring divider, one quotient
// bit per stage. Also picks the arcade or curvature result.
// ============================================================================
module ddm_scale #(
    parameter  int FRAC_BITS = 8,
    localparam int AW        = ddm_pkg::a_width(FRAC_BITS)
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_en,
    input  wire ddm_pkg::t_mix_ctl                 i_ctl,
    input  wire logic signed [ddm_pkg::OUT_W-1:0]  i_arc_l,
    input  wire logic signed [ddm_pkg::OUT_W-1:0]  i_arc_r,
    input  wire logic signed [AW-1:0]              i_a,
    input  wire logic signed [AW-1:0]              i_b,
    output      logic                              o_valid,
    output      logic signed [ddm_pkg::OUT_W-1:0]  o_left,
    output      logic signed [ddm_pkg::OUT_W-1:0]  o_right
);

    localparam longint FS = ddm_pkg::full_scale(FRAC_BITS);
    localparam int     Q  = $clog2(FS + 1);
    localparam int     NW = AW + Q;

    localparam logic signed [AW-1:0] A_MAX = AW'(65535);
    localparam logic signed [AW-1:0] A_MIN = AW'(-65536);

    typedef struct packed {
        logic              curv;
        logic              need;
        logic              sa;
        logic              sb;
        logic signed [16:0] a_sat;
        logic signed [16:0] b_sat;
        logic signed [16:0] arc_l;
        logic signed [16:0] arc_r;
    } t_side;

    // Magnitude stage.
    logic                 r_m_valid, r_m_curv;
    logic [AW-1:0]        r_m_am, r_m_bm;
    logic                 r_m_sa, r_m_sb;
    logic signed [16:0]   r_m_asat, r_m_bsat, r_m_arc_l, r_m_arc_r;

    // Divider stages; index 0 holds the numerators.
    logic                 r_vld  [0:Q];
    t_side                r_side [0:Q];
    logic [AW-1:0]        r_d    [0:Q];
    logic [NW-1:0]        r_rema [0:Q];
    logic [NW-1:0]        r_remb [0:Q];
    logic [Q-1:0]         r_qa   [0:Q];
    logic [Q-1:0]         r_qb   [0:Q];

    logic [AW-1:0]        n_m;
    logic signed [16:0]   n_asat, n_bsat;
    logic signed [16:0]   n_qa_s, n_qb_s, n_l, n_r;

    always_comb begin
        if (i_a > A_MAX) begin
            n_asat = ddm_pkg::OUT_MAX;
        end else if (i_a < A_MIN) begin
            n_asat = ddm_pkg::OUT_MIN;
        end else begin
            n_asat = i_a[16:0];
        end
        if (i_b > A_MAX) begin
            n_bsat = ddm_pkg::OUT_MAX;
        end else if (i_b < A_MIN) begin
            n_bsat = ddm_pkg::OUT_MIN;
        end else begin
            n_bsat = i_b[16:0];
        end
        n_m = (r_m_am >= r_m_bm) ? r_m_am : r_m_bm;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_vld[0]  <= 1'b0;
        end else if (i_en) begin
            r_m_valid <= i_ctl.valid;
            r_vld[0]  <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m_curv  <= i_ctl.curv;
            r_m_am    <= AW'(i_a[AW-1] ? -i_a : i_a);
            r_m_bm    <= AW'(i_b[AW-1] ? -i_b : i_b);
            r_m_sa    <= i_a[AW-1];
            r_m_sb    <= i_b[AW-1];
            r_m_asat  <= n_asat;
            r_m_bsat  <= n_bsat;
            r_m_arc_l <= i_arc_l;
            r_m_arc_r <= i_arc_r;

            r_side[0].curv  <= r_m_curv;
            r_side[0].need  <= 64'(n_m) > FS;
            r_side[0].sa    <= r_m_sa;
            r_side[0].sb    <= r_m_sb;
            r_side[0].a_sat <= r_m_asat;
            r_side[0].b_sat <= r_m_bsat;
            r_side[0].arc_l <= r_m_arc_l;
            r_side[0].arc_r <= r_m_arc_r;
            r_d[0]          <= n_m;
            // Numerator |value| * 127 << FRAC_BITS, as shift and subtract.
            r_rema[0] <= ((NW'(r_m_am) << 7) - NW'(r_m_am)) << FRAC_BITS;
            r_remb[0] <= ((NW'(r_m_bm) << 7) - NW'(r_m_bm)) << FRAC_BITS;
            r_qa[0]   <= '0;
            r_qb[0]   <= '0;
        end
    end

    for (genvar s = 0; s < Q; s++) begin : g_div
        localparam int J = Q - 1 - s;

        logic [NW-1:0] dsh;
        logic          ge_a, ge_b;
        logic [NW-1:0] n_rema, n_remb;
        logic [Q-1:0]  n_qa, n_qb;

        always_comb begin
            dsh    = NW'(r_d[s]) << J;
            ge_a   = r_rema[s] >= dsh;
            ge_b   = r_remb[s] >= dsh;
            n_rema = ge_a ? r_rema[s] - dsh : r_rema[s];
            n_remb = ge_b ? r_remb[s] - dsh : r_remb[s];
            n_qa    = r_qa[s];
            n_qa[J] = ge_a;
            n_qb    = r_qb[s];
            n_qb[J] = ge_b;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[s+1] <= r_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[s+1] <= r_side[s];
                r_d[s+1]    <= r_d[s];
                r_rema[s+1] <= n_rema;
                r_remb[s+1] <= n_remb;
                r_qa[s+1]   <= n_qa;
                r_qb[s+1]   <= n_qb;
            end
        end
    end

    // Apply the sign and saturate the quotients to the output range.
    always_comb begin
        if (!r_side[Q].sa && (64'(r_qa[Q]) > 64'd65535)) begin
            n_qa_s = ddm_pkg::OUT_MAX;
        end else if (r_side[Q].sa && (64'(r_qa[Q]) > 64'd65536)) begin
            n_qa_s = ddm_pkg::OUT_MIN;
        end else begin
            n_qa_s = r_side[Q].sa ? -$signed(17'(r_qa[Q])) : $signed(17'(r_qa[Q]));
        end
        if (!r_side[Q].sb && (64'(r_qb[Q]) > 64'd65535)) begin
            n_qb_s = ddm_pkg::OUT_MAX;
        end else if (r_side[Q].sb && (64'(r_qb[Q]) > 64'd65536)) begin
            n_qb_s = ddm_pkg::OUT_MIN;
        end else begin
            n_qb_s = r_side[Q].sb ? -$signed(17'(r_qb[Q])) : $signed(17'(r_qb[Q]));
        end

        if (!r_side[Q].curv) begin
            n_l = r_side[Q].arc_l;
            n_r = r_side[Q].arc_r;
        end else if (r_side[Q].need) begin
            n_l = n_qa_s;
            n_r = n_qb_s;
        end else begin
            n_l = r_side[Q].a_sat;
            n_r = r_side[Q].b_sat;
        end
    end

    assign o_valid = r_vld[Q];
    assign o_left  = n_l;
    assign o_right = n_r;

    // The side with the larger magnitude always lands exactly on full scale.
    a_full_scale_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[Q] && r_side[Q].curv && r_side[Q].need
        |-> (r_qa[Q] == Q'(FS)) || (r_qb[Q] == Q'(FS)))
        else $error("normalized curvature item misses full scale");

    a_quot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[Q] && r_side[Q].curv && r_side[Q].need
        |-> (64'(r_qa[Q]) <= FS) && (64'(r_qb[Q]) <= FS))
        else $error("divider quotient above full scale");

endmodule
`default_nettype wire

// ===== rtl/differential_drive_mixer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Differential drive mixer core
// Mixes throttle and turn samples into left and right wheel power, in arcade
// or curvature mode, selected through the register write channel.
// ============================================================================
// The core takes one sample per clock, unless a result waits at the output,
// and returns one result per sample, in order. Seven stages do the arcade
// desaturation and the curvature turn term, two find the larger curvature
// magnitude, 7 + FRAC_BITS stages form the restoring divider that scales
// curvature results down to full scale at one quotient bit each, and one is
// the output register. While a result waits at the output the whole pipeline
// holds and no sample is taken. Register writes are taken every cycle and
// should come only while the core is empty.
module differential_drive_mixer_core #(
    parameter int FRAC_BITS = 8
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ddm_in_if.sink      i_in,
    ddm_out_if.source   o_out,
    ddm_cfg_if.sink     i_cfg
);

    localparam int AW = ddm_pkg::a_width(FRAC_BITS);

    logic                              r_mode;
    logic [ddm_pkg::BIAS_W-1:0]        r_bias;
    logic                              r_out_valid;
    logic signed [ddm_pkg::OUT_W-1:0]  r_out_left, r_out_right;

    logic                              adv;
    ddm_pkg::t_mix_ctl                 mix_ctl;
    logic signed [ddm_pkg::OUT_W-1:0]  arc_l, arc_r;
    logic signed [AW-1:0]              curv_a, curv_b;
    logic                              sc_valid;
    logic signed [ddm_pkg::OUT_W-1:0]  sc_left, sc_right;

    assign adv         = !r_out_valid || o_out.ready;
    assign i_in.ready  = adv;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= ddm_pkg::DRIVE_ARCADE;
            r_bias <= ddm_pkg::BIAS_HALF;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                ddm_pkg::REG_DRIVE_MODE: begin
                    r_mode <= i_cfg.data[0];
                end
                ddm_pkg::REG_DESAT_BIAS: begin
                    r_bias <= i_cfg.data;
                end
                default: begin
                end
            endcase
        end
    end

    ddm_mix #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mix (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (adv),
        .i_valid    (i_in.valid),
        .i_throttle (i_in.throttle_in),
        .i_turn     (i_in.turn_in),
        .i_mode     (r_mode),
        .i_bias     (r_bias),
        .o_ctl      (mix_ctl),
        .o_arc_l    (arc_l),
        .o_arc_r    (arc_r),
        .o_a        (curv_a),
        .o_b        (curv_b)
    );

    ddm_scale #(
        .FRAC_BITS (FRAC_BITS)
    ) u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_ctl   (mix_ctl),
        .i_arc_l (arc_l),
        .i_arc_r (arc_r),
        .i_a     (curv_a),
        .i_b     (curv_b),
        .o_valid (sc_valid),
        .o_left  (sc_left),
        .o_right (sc_right)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= sc_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_left  <= sc_left;
            r_out_right <= sc_right;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.left_power  = r_out_left;
    assign o_out.right_power = r_out_right;

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out.valid)
        else $error("result shown right after reset");

    a_stall_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |-> !i_in.ready)
        else $error("sample taken while the pipeline is held");

endmodule
`default_nettype wire
